// ===== rtl/assert_macros.svh =====
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// while the asynchronous active-low reset is asserted.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/irht_pkg.sv =====
//------------------------------------------------------------------------------
// irht_pkg
// Types, constants and helpers shared by the id relabel hash table.
//------------------------------------------------------------------------------
package irht_pkg;

	localparam int ADDR_BITS  = 12;
	localparam int ID_WIDTH   = 32;
	localparam int IN_ID_W    = 32;
	localparam int KEY_W      = (ID_WIDTH < IN_ID_W) ? ID_WIDTH : IN_ID_W;
	localparam int IDX_W      = 12;
	localparam int OUT_DATA_W = 16;
	localparam int SIZE_W     = 4;
	localparam int BITS_W     = $clog2(ADDR_BITS + 1);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(12);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NEW       = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_CLEARED   = 3'd5
	} stat_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_CHECK,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic                 used;
		logic [KEY_W-1:0]     key;
		logic [ADDR_BITS-1:0] idx;
	} slot_t;

	typedef struct packed {
		logic  load;
		logic  clr_start;
		logic  sweep_wr;
		logic  rd_en;
		logic  step;
		logic  ins_wr;
		logic  res_set;
		stat_t res_status;
		logic  out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_used;
		logic key_match;
		logic probe_last;
		logic sweep_last;
		logic idx_full;
		logic out_free;
	} dp_stat_t;

	// clamp size register to 1..ADDR_BITS
	function automatic logic [BITS_W-1:0] eff_bits(input logic [SIZE_W-1:0] sb);
		logic [BITS_W-1:0] r;
		if (sb == '0)
			r = BITS_W'(1);
		else if (int'(sb) > ADDR_BITS)
			r = BITS_W'(ADDR_BITS);
		else
			r = BITS_W'(sb);
		return r;
	endfunction

endpackage

// ===== rtl/id_relabel_hash_table.sv =====
//------------------------------------------------------------------------------
// id_relabel_hash_table
// Open-addressing id table that hands each distinct id a compact index.
//------------------------------------------------------------------------------
// Each input word is a command (insert, lookup, clear or unused) and an id;
// each one returns exactly one result word with a status and an index. Slots
// are probed from id & mask, then pos += delta^2 with delta = 1, 2 and so on.
// Each probe is a read state, then a compare state, on the single-read slot
// RAM; an insert or lookup touches at most 2^size_bits slots, and the next
// word is taken only after its result has moved into the output register. A
// clear sweeps every slot of the RAM, one per cycle. After reset the same
// clearing pass runs before the first word is accepted; size writes are taken
// during it. The input side accepts one word at a time and can take the next
// one while a finished result still waits on the output.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module id_relabel_hash_table import irht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] id
	input  logic [1:0]            s_tuser,   // [1:0] cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] index, [15:12] zero
	output logic [2:0]            m_tuser,   // [2:0] status
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [SIZE_W-1:0]     cfg_data
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     out_miss;
	logic     clear_acc;

	assign cfg_ready = 1'b1;

	irht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op_in    (cmd_t'(s_tuser)),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	irht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.id        (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	assign out_miss  = m_tvalid && !(m_tuser inside {ST_NEW, ST_PRESENT, ST_FOUND});
	assign clear_acc = s_tvalid && s_tready && s_tuser == CMD_CLEAR;

	`ASSERT_NEVER(a_no_accept_in_sweep, clk, arst_n, dp_cmd.sweep_wr && s_tready, "accept in sweep")
	`ASSERT_NEVER(a_one_writer, clk, arst_n, dp_cmd.sweep_wr && dp_cmd.ins_wr, "two slot writers")
	`ASSERT_IMPL(a_index_zero, clk, arst_n, out_miss, m_tdata == '0, "nonzero index on miss")
	`ASSERT_NEXT(a_clear_blocks, clk, arst_n, clear_acc, !s_tready, "input open after clear")

endmodule

// ===== rtl/irht_ram.sv =====
//------------------------------------------------------------------------------
// irht_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module irht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/irht_ctrl.sv =====
//------------------------------------------------------------------------------
// irht_ctrl
// Sequencer: clearing sweep, probe read/check loop and result hand-off.
//------------------------------------------------------------------------------
module irht_ctrl import irht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  cmd_t     op_in,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	cmd_t   op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			op_q    <= CMD_NONE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.res_status = ST_NOT_FOUND;
		case (state_q)
			S_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					op_d     = op_in;
					case (op_in)
						CMD_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = S_CLEAR;
						end
						CMD_INSERT, CMD_LOOKUP: begin
							state_d = S_READ;
						end
						default: begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
							state_d        = S_WAIT;
						end
					endcase
				end
			end
			S_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_CLEARED;
					state_d        = S_WAIT;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if (!stat.slot_used) begin
					cmd.res_set = 1'b1;
					state_d     = S_WAIT;
					if (op_q == CMD_INSERT) begin
						if (stat.idx_full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.ins_wr     = 1'b1;
							cmd.res_status = ST_NEW;
						end
					end else begin
						cmd.res_status = ST_NOT_FOUND;
					end
				end else if (stat.key_match) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = (op_q == CMD_INSERT) ? ST_PRESENT : ST_FOUND;
					state_d        = S_WAIT;
				end else if (stat.probe_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = (op_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
					state_d        = S_WAIT;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_READ;
				end
			end
			S_WAIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule

// ===== rtl/irht_dp.sv =====
//------------------------------------------------------------------------------
// irht_dp
// Datapath: slot RAM, probe position arithmetic, index counter, size
// register and output word register.
//------------------------------------------------------------------------------
module irht_dp import irht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_ID_W-1:0]    id,
	input  logic                  cfg_valid,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]            m_tuser
);

	logic [SIZE_W-1:0]    size_q;
	logic [KEY_W-1:0]     key_q;
	logic [ADDR_BITS-1:0] pos_q;
	logic [ADDR_BITS-1:0] sq_q;
	logic [ADDR_BITS-1:0] delta_q;
	logic [ADDR_BITS:0]   cnt_q;
	logic [ADDR_BITS:0]   next_index_q;
	logic [ADDR_BITS-1:0] sweep_q;
	stat_t                res_status_q;
	logic [IDX_W-1:0]     res_index_q;
	logic                 out_valid_q;
	stat_t                out_status_q;
	logic [IDX_W-1:0]     out_index_q;

	logic [BITS_W-1:0]    bits;
	logic [ADDR_BITS-1:0] mask;
	logic [KEY_W-1:0]     key_in;
	logic                 wr_en;
	logic [ADDR_BITS-1:0] wr_addr;
	slot_t                wr_data;
	slot_t                rd_data;

	assign bits   = eff_bits(size_q);
	assign mask   = {ADDR_BITS{1'b1}} >> (BITS_W'(ADDR_BITS) - bits);
	assign key_in = KEY_W'(id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= SIZE_RESET;
		else if (cfg_valid)
			size_q <= cfg_data;
	end

	// probe walk: pos += delta^2, squares kept incrementally
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= key_in;
			pos_q   <= ADDR_BITS'(key_in) & mask;
			sq_q    <= ADDR_BITS'(1);
			delta_q <= ADDR_BITS'(1);
			cnt_q   <= '0;
		end else if (cmd.step) begin
			pos_q   <= (pos_q + sq_q) & mask;
			sq_q    <= sq_q + (delta_q << 1) + ADDR_BITS'(1);
			delta_q <= delta_q + ADDR_BITS'(1);
			cnt_q   <= cnt_q + (ADDR_BITS+1)'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_index_q <= '0;
			sweep_q      <= '0;
		end else begin
			if (cmd.clr_start)
				next_index_q <= '0;
			else if (cmd.ins_wr)
				next_index_q <= next_index_q + (ADDR_BITS+1)'(1);
			if (cmd.clr_start)
				sweep_q <= '0;
			else if (cmd.sweep_wr)
				sweep_q <= sweep_q + ADDR_BITS'(1);
		end
	end

	assign wr_en   = cmd.sweep_wr | cmd.ins_wr;
	assign wr_addr = cmd.sweep_wr ? sweep_q : pos_q;

	always_comb begin
		wr_data      = '0;
		if (!cmd.sweep_wr) begin
			wr_data.used = 1'b1;
			wr_data.key  = key_q;
			wr_data.idx  = next_index_q[ADDR_BITS-1:0];
		end
	end

	irht_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (1 << ADDR_BITS)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	assign stat.slot_used  = rd_data.used;
	assign stat.key_match  = (rd_data.key == key_q);
	assign stat.probe_last = (cnt_q == {1'b0, mask});
	assign stat.sweep_last = &sweep_q;
	assign stat.idx_full   = next_index_q[ADDR_BITS];
	assign stat.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_status)
				ST_NEW:              res_index_q <= IDX_W'(next_index_q[ADDR_BITS-1:0]);
				ST_PRESENT, ST_FOUND: res_index_q <= IDX_W'(rd_data.idx);
				default:             res_index_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-IDX_W){1'b0}}, out_index_q};
	assign m_tuser  = out_status_q;

endmodule

// ===== tb/id_relabel_checker.sv =====
//------------------------------------------------------------------------------
// id_relabel_checker
// Watches the command, result and size channels of the id relabel table.
// Keeps its own copy of the slot store and the index counter, works out the
// result of every accepted command word and compares the result words with
// these expectations in order.
//------------------------------------------------------------------------------
module id_relabel_checker import irht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [2:0]            m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [SIZE_W-1:0]     cfg_data,
	output int                    fail_count = 0,
	output int                    pending = 0
);

	localparam int SLOTS = 1 << ADDR_BITS;

	typedef struct packed {
		stat_t            status;
		logic [IDX_W-1:0] index;
	} outcome_t;

	logic [KEY_W-1:0]     key_mem [SLOTS];
	logic                 used_mem [SLOTS];
	logic [IDX_W-1:0]     idx_mem [SLOTS];
	int unsigned          next_idx;
	logic [SIZE_W-1:0]    size_q;
	outcome_t             outcome_q[$];

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= 100)
			$display("ERROR: %s", msg);
	endtask

	function automatic outcome_t relabel_outcome(input cmd_t cmd, input logic [KEY_W-1:0] id);
		int unsigned bits;
		int unsigned mask;
		int unsigned pos;
		int unsigned delta;
		bit          hit;
		bit          placed;
		outcome_t    o;
		o.status = ST_NOT_FOUND;
		o.index  = '0;
		hit      = 1'b0;
		placed   = 1'b0;
		bits = (size_q == 0) ? 1 : ((int'(size_q) > ADDR_BITS) ? ADDR_BITS : int'(size_q));
		mask = (1 << bits) - 1;
		pos  = id & mask;
		delta = 1;
		if (cmd == CMD_CLEAR) begin
			for (int i = 0; i < SLOTS; i++)
				used_mem[i] = 1'b0;
			next_idx = 0;
			o.status = ST_CLEARED;
			return o;
		end
		if (cmd != CMD_INSERT && cmd != CMD_LOOKUP)
			return o;
		// quadratic walk, at most one pass worth of probes
		for (int n = 0; n < (1 << bits); n++) begin
			if (!used_mem[pos]) begin
				placed = 1'b1;
				break;
			end
			if (key_mem[pos] == id) begin
				placed = 1'b1;
				hit    = 1'b1;
				break;
			end
			pos = (pos + delta * delta) & mask;
			delta++;
		end
		if (cmd == CMD_INSERT) begin
			if (!placed) begin
				o.status = ST_FULL;
			end else if (hit) begin
				o.status = ST_PRESENT;
				o.index  = idx_mem[pos];
			end else if (next_idx >= SLOTS) begin
				o.status = ST_FULL;
			end else begin
				used_mem[pos] = 1'b1;
				key_mem[pos]  = id;
				idx_mem[pos]  = IDX_W'(next_idx);
				o.index       = IDX_W'(next_idx);
				o.status      = ST_NEW;
				next_idx++;
			end
		end else if (hit) begin
			o.status = ST_FOUND;
			o.index  = idx_mem[pos];
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				used_mem[i] = 1'b0;
			next_idx = 0;
			size_q   = SIZE_RESET;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				size_q = cfg_data;
			// results first: a word accepted at this edge cannot answer itself
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					flag_error($sformatf("result word with nothing expected: status %0d index %0d",
						m_tuser, m_tdata));
				end else begin
					want = outcome_q.pop_front();
					if (m_tuser !== want.status)
						flag_error($sformatf("status: expected %0d, got %0d", want.status, m_tuser));
					if (m_tdata !== OUT_DATA_W'(want.index))
						flag_error($sformatf("index: expected %0d, got %0d", want.index, m_tdata));
				end
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(relabel_outcome(cmd_t'(s_tuser), s_tdata[KEY_W-1:0]));
			pending <= outcome_q.size();
		end
	end

endmodule

// ===== tb/id_relabel_hash_table_tb.sv =====
//------------------------------------------------------------------------------
// id_relabel_hash_table_tb
// Drives insert, lookup, clear and unused command words into the id table
// under several table sizes, with random gaps on both sides, one long output
// stall and pauses that drain the block before each size write. A separate
// checker predicts and compares every result word.
//------------------------------------------------------------------------------
module id_relabel_hash_table_tb;
	import irht_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int TARGET_WORDS   = 1700;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [31:0] id
	logic [1:0]            s_tuser = '0;   // [1:0] cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [11:0] index, [15:12] zero
	logic [2:0]            m_tuser;        // [2:0] status
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SIZE_W-1:0]     cfg_data = '0;

	int                    fail_count;
	int                    pending;
	int                    sent_cnt = 0;
	int                    hold_left = 0;
	bit                    hold_done = 1'b0;
	int                    quiet_cycles = 0;
	logic [31:0]           known_ids[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	id_relabel_hash_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	id_relabel_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// result side: random stalls, one long hold while words keep coming, a calm window
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!hold_done && sent_cnt >= 300) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_tready  <= 1'b0;
		end else if (sent_cnt >= 900 && sent_cnt < 1100) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_word(input cmd_t cmd, input logic [31:0] id);
		if (!(sent_cnt >= 900 && sent_cnt < 1100) && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= id;
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
		if (cmd == CMD_INSERT) begin
			known_ids.push_back(id);
			if (known_ids.size() > 256)
				void'(known_ids.pop_front());
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mix of reused ids, small ids, low-bit collisions and full-range ids
	function automatic logic [31:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && known_ids.size() != 0)
			return known_ids[$urandom_range(0, known_ids.size() - 1)];
		else if (r < 75)
			return $urandom_range(0, 63);
		else if (r < 90)
			return ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 3);
		else
			return $urandom;
	endfunction

	initial begin
		logic [SIZE_W-1:0] edge_sizes[5];
		int                r;
		int                n;
		edge_sizes = '{4'd0, 4'd1, 4'd12, 4'd13, 4'd15};

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: taken during the clearing pass after reset
		write_size(4'd12);
		send_word(CMD_INSERT, 32'h0000_0000);
		send_word(CMD_INSERT, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, 32'h0000_0000);
		send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
		send_word(CMD_LOOKUP, 32'h1234_5678);
		send_word(CMD_NONE,   32'h0000_0000);
		send_word(CMD_INSERT, 32'h0000_1000);
		send_word(CMD_LOOKUP, 32'h0000_1000);
		// size below range, table already holding entries
		write_size(4'd0);
		send_word(CMD_INSERT, 32'h0000_0005);
		send_word(CMD_LOOKUP, 32'h0000_0000);
		send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
		// size above range
		write_size(4'd15);
		send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
		send_word(CMD_CLEAR,  32'hA5A5_A5A5);
		send_word(CMD_LOOKUP, 32'h0000_0000);
		send_word(CMD_INSERT, 32'h0000_0007);
		// two-slot table runs out of probes
		write_size(4'd1);
		send_word(CMD_INSERT, 32'h0000_0008);
		send_word(CMD_INSERT, 32'h0000_0009);
		send_word(CMD_INSERT, 32'h0000_000A);
		send_word(CMD_LOOKUP, 32'h0000_000A);
		send_word(CMD_INSERT, 32'h0000_0009);
		send_word(CMD_CLEAR,  32'h0000_0000);

		while (sent_cnt < TARGET_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				write_size(edge_sizes[$urandom_range(0, 4)]);
			else if (r < 75)
				write_size(SIZE_W'($urandom_range(2, 6)));
			else
				write_size(SIZE_W'($urandom_range(7, 11)));
			if ($urandom_range(0, 99) < 60)
				send_word(CMD_CLEAR, $urandom);
			n = $urandom_range(10, 70);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 52)
					send_word(CMD_INSERT, pick_id());
				else if (r < 92)
					send_word(CMD_LOOKUP, pick_id());
				else if (r < 97)
					send_word(CMD_NONE, $urandom);
				else
					send_word(CMD_CLEAR, $urandom);
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/irht_pkg.sv
rtl/irht_ram.sv
rtl/irht_ctrl.sv
rtl/irht_dp.sv
rtl/id_relabel_hash_table.sv
tb/id_relabel_checker.sv
tb/id_relabel_hash_table_tb.sv
